// ----- rtl/spas_pkg.sv -----
// ============================================================================
// spas_pkg
// Shared types and constants for the sparse polynomial add/sub merge block.
// ============================================================================
package spas_pkg;

    localparam int COEFF_W = 32;
    localparam int EXP_W   = 16;
    localparam int TERM_W  = COEFF_W + EXP_W;
    localparam int CMD_W   = 2;

    // Input command codes carried on the slave tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_START  = 2'd2
    } t_cmd;

    // Controller states
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_a;   // store input term in list A
        logic load_b;   // store input term in list B
        logic step;     // emit one merged term into the output register
        logic clear;    // end of merge: empty both lists and the drop flag
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;   // output register can take a term this cycle
        logic last_step;  // the term emitted now ends the merge
    } t_dp_sts;

endpackage

// ----- rtl/spas_ram.sv -----
// ============================================================================
// spas_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module spas_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/spas_ctrl.sv -----
// ============================================================================
// spas_ctrl
// Controller: accepts load/start transactions and sequences the merge.
// ============================================================================
module spas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [spas_pkg::CMD_W-1:0] i_cmd,
    input  spas_pkg::t_dp_sts i_sts,
    output spas_pkg::t_dp_cmd o_cmd
);
    import spas_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands; input is always ready while idle
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    case (t_cmd'(i_cmd))
                        CMD_LOAD_A: o_cmd.load_a = 1'b1;
                        CMD_LOAD_B: o_cmd.load_b = 1'b1;
                        CMD_START:  n_state = ST_MERGE;
                        default:    ;  // unknown command, dropped
                    endcase
                end
            end
            ST_MERGE: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.last_step) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/spas_dp.sv -----
// ============================================================================
// spas_dp
// Datapath: term stores, list counters, head compare, saturating add/sub
// and the output register.
// ============================================================================
module spas_dp #(
    parameter int MAX_TERMS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic [spas_pkg::COEFF_W-1:0]  i_coeff,
    input  logic [spas_pkg::EXP_W-1:0]    i_exp,
    input  spas_pkg::t_dp_cmd             i_cmd,
    output spas_pkg::t_dp_sts             o_sts,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [spas_pkg::TERM_W-1:0]   m_axis_tdata,   // [31:0] coeff_out, [47:32] exp_out
    output logic                          m_axis_tlast,   // last_term
    output logic [1:0]                    m_axis_tuser    // [0] no_terms, [1] overflow
);
    import spas_pkg::*;

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TERMS);

    logic              r_sub;
    logic              r_dropped;
    logic [CW-1:0]     r_a_cnt, r_b_cnt;
    logic [CW-1:0]     r_ia, r_ib;
    logic [CW-1:0]     n_ia, n_ib;
    logic [TERM_W-1:0] a_rdata, b_rdata;
    logic              we_a, we_b;

    logic                     a_rem, b_rem, empty, take_a, take_b;
    logic signed [EXP_W-1:0]  ea, eb;
    logic signed [COEFF_W:0]  va, vb, sum;
    logic [COEFF_W-1:0]       sat;
    logic [CW-1:0]            ia_inc, ib_inc;

    logic              r_ov;
    logic [COEFF_W-1:0] r_coeff;
    logic [EXP_W-1:0]  r_exp;
    logic              r_last, r_none, r_oflow;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (i_cfg_we) begin
            r_sub <= i_cfg_wdata;
        end
    end

    // term stores, read at the next head pointer
    assign we_a = i_cmd.load_a && (r_a_cnt < MAX_CNT);
    assign we_b = i_cmd.load_b && (r_b_cnt < MAX_CNT);

    spas_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_a_cnt[AW-1:0]),
        .i_wdata ({i_exp, i_coeff}),
        .i_raddr (n_ia[AW-1:0]),
        .o_rdata (a_rdata)
    );

    spas_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_b_cnt[AW-1:0]),
        .i_wdata ({i_exp, i_coeff}),
        .i_raddr (n_ib[AW-1:0]),
        .o_rdata (b_rdata)
    );

    // head selection
    assign ea    = a_rdata[TERM_W-1:COEFF_W];
    assign eb    = b_rdata[TERM_W-1:COEFF_W];
    assign a_rem = r_ia < r_a_cnt;
    assign b_rem = r_ib < r_b_cnt;
    assign empty = (r_a_cnt == '0) && (r_b_cnt == '0);

    always_comb begin
        if (a_rem && b_rem) begin
            take_a = (ea >= eb);
            take_b = (eb >= ea);
        end else begin
            take_a = a_rem;
            take_b = !a_rem;
        end
    end

    // saturating add/sub; a missing operand is zero
    assign va  = take_a ? {a_rdata[COEFF_W-1], a_rdata[COEFF_W-1:0]} : '0;
    assign vb  = take_b ? {b_rdata[COEFF_W-1], b_rdata[COEFF_W-1:0]} : '0;
    assign sum = r_sub ? (va - vb) : (va + vb);

    always_comb begin
        if (sum[COEFF_W] != sum[COEFF_W-1]) begin
            sat = sum[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}} : {1'b0, {(COEFF_W-1){1'b1}}};
        end else begin
            sat = sum[COEFF_W-1:0];
        end
    end

    // pointer advance
    assign ia_inc = r_ia + CW'(take_a);
    assign ib_inc = r_ib + CW'(take_b);

    assign o_sts.last_step = empty || ((ia_inc >= r_a_cnt) && (ib_inc >= r_b_cnt));
    assign o_sts.out_free  = !r_ov || m_axis_tready;

    always_comb begin
        n_ia = r_ia;
        n_ib = r_ib;
        if (i_cmd.clear) begin
            n_ia = '0;
            n_ib = '0;
        end else if (i_cmd.step) begin
            n_ia = ia_inc;
            n_ib = ib_inc;
        end
    end

    // counters, pointers and drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_cnt   <= '0;
            r_b_cnt   <= '0;
            r_ia      <= '0;
            r_ib      <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_ia <= n_ia;
            r_ib <= n_ib;
            if (i_cmd.clear) begin
                r_a_cnt   <= '0;
                r_b_cnt   <= '0;
                r_dropped <= 1'b0;
            end else begin
                if (we_a) r_a_cnt <= r_a_cnt + 1'b1;
                if (we_b) r_b_cnt <= r_b_cnt + 1'b1;
                if ((i_cmd.load_a && !we_a) || (i_cmd.load_b && !we_b)) begin
                    r_dropped <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.step) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_coeff <= empty ? '0 : sat;
            r_exp   <= empty ? '0 : (take_a ? ea : eb);
            r_last  <= o_sts.last_step;
            r_none  <= empty;
            r_oflow <= r_dropped;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_exp, r_coeff};
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = {r_oflow, r_none};

endmodule

// ----- rtl/sparse_polynomial_add_sub_merge.sv -----
// ============================================================================
// sparse_polynomial_add_sub_merge
// Adds or subtracts two sparse polynomials held as descending term lists.
// ============================================================================
// Load transactions (tuser 0 for list A, 1 for list B) are accepted while idle and
// store a Q16.16 coefficient and signed exponent; loads beyond MAX_TERMS per
// list are dropped and raise the overflow flag. A start transaction (tuser 2)
// runs the merge: the input stalls while terms leave at one per cycle whenever
// the output register is free, read from the two term RAMs and held in the
// output register. An empty merge returns one item flagged no_terms. Both
// lists and the overflow flag are empty again once the last term is registered.
// The user must write subtract_mode through i_cfg_we only while idle; the block
// itself does not enforce it.
module sparse_polynomial_add_sub_merge #(
    parameter int MAX_TERMS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] coeff_in, [47:32] exp_in
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] coeff_out, [47:32] exp_out
    output logic        m_axis_tlast,   // last_term
    output logic [1:0]  m_axis_tuser    // [0] no_terms, [1] overflow
);
    import spas_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    spas_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_cmd         (s_axis_tuser),
        .i_sts         (dp_sts),
        .o_cmd         (dp_cmd)
    );

    spas_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_coeff       (s_axis_tdata[COEFF_W-1:0]),
        .i_exp         (s_axis_tdata[TERM_W-1:COEFF_W]),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
